// ===== rtl/core/rce_pkg.sv =====
// ----------------------------------------------------------------------------
// rce_pkg: shared types and codes for the rectangle corner extent block
// Holds the request codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rce_pkg;

  // width of coordinates, limits and run lengths
  localparam int CNT_W = 7;

  // request action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_ROWS_USED = 1'b0;
  localparam logic REG_COLS_USED = 1'b1;

  typedef struct packed {
    logic             is_corner;
    logic [CNT_W-1:0] width;
    logic [CNT_W-1:0] height;
  } rce_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rectangle_corner_extent.sv =====
// ----------------------------------------------------------------------------
// rectangle_corner_extent: corner and extent queries on a stored binary map
//
// Input requests (in_valid / in_stall) either write one map cell or query one
// cell. A write gives no result. A query gives one result on the out_ channel:
// whether the cell is a top-left corner of a region of ones, and if so the run
// lengths downward (height) and rightward (width) within the rows and columns in
// use (cfg registers rows_used, cols_used).
// A query reads the cell, its top and left neighbours, then down the column and
// along the row; every step is one read through the cell store's single read
// port, whose data arrives in the next cycle. A query outside the used area reads
// no cells and goes straight to its result. One request is handled
// at a time; in_stall is high while a query is being worked on.
// The result sits in an output register; a held out_stall keeps it there and
// the next query waits at its end until that register frees up, holding off
// every further request meanwhile.
// Reset sets rows_used and cols_used to 64 and empties the output register.
// The cell store is not cleared; only cells that were written may be queried.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rectangle_corner_extent
  import rce_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_action,
  input  wire logic [5:0]       in_row,
  input  wire logic [5:0]       in_col,
  input  wire logic             in_cell_value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_is_corner,
  output logic [CNT_W-1:0]      out_width,
  output logic [CNT_W-1:0]      out_height
);

  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int ADDR_W = 2 * SIDE_W;

  logic [CNT_W-1:0] rows_used_r, rows_used_nxt;
  logic [CNT_W-1:0] cols_used_r, cols_used_nxt;
  logic [CNT_W-1:0] n_rows, n_cols;

  logic              out_valid_r, out_valid_nxt;
  rce_result_t       out_res_r, out_res_nxt;

  logic              ctrl_idle;
  logic              mem_we, mem_wdata, mem_re, mem_rdata;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic              res_valid, res_take;
  rce_result_t       res;

  // configuration
  always_comb begin
    rows_used_nxt = rows_used_r;
    cols_used_nxt = cols_used_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_USED: rows_used_nxt = cfg_wdata;
        REG_COLS_USED: cols_used_nxt = cfg_wdata;
        default: begin
          rows_used_nxt = rows_used_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= 7'd64;
      cols_used_r <= 7'd64;
    end else begin
      rows_used_r <= rows_used_nxt;
      cols_used_r <= cols_used_nxt;
    end
  end

  // limits beyond the store size act as the store size
  assign n_rows = (32'(rows_used_r) > MAX_SIDE) ? CNT_W'(MAX_SIDE) : rows_used_r;
  assign n_cols = (32'(cols_used_r) > MAX_SIDE) ? CNT_W'(MAX_SIDE) : cols_used_r;

  assign in_stall = !ctrl_idle;

  rce_ctrl #(
    .MAX_SIDE (MAX_SIDE),
    .SIDE_W   (SIDE_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_valid),
    .req_action     (in_action),
    .req_row        (in_row),
    .req_col        (in_col),
    .req_cell_value (in_cell_value),
    .idle           (ctrl_idle),
    .n_rows         (n_rows),
    .n_cols         (n_cols),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res)
  );

  rce_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_is_corner = out_res_r.is_corner;
  assign out_width     = out_res_r.width;
  assign out_height    = out_res_r.height;

  // no corner means empty runs
  a_no_corner_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_corner) |-> (out_width == '0 && out_height == '0))
    else $error("non-corner result with non-zero extent");

  // a corner always covers at least its own cell
  a_corner_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_corner) |-> (out_width != '0 && out_height != '0))
    else $error("corner result with empty extent");

  // the store is written only by an accepted write request
  a_write_source : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (in_valid && !in_stall && in_action == ACT_WRITE))
    else $error("cell store written without a write request");

  // a query in progress never issues a store write
  a_busy_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl_idle |-> !mem_we)
    else $error("cell store written during a query");

endmodule

`default_nettype wire

// ===== rtl/core/rce_mem.sv =====
// ----------------------------------------------------------------------------
// rce_mem: single-bit cell store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rce_mem #(
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic              wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic                   rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic mem_r [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/rce_ctrl.sv =====
// ----------------------------------------------------------------------------
// rce_ctrl: request sequencer
// Stores write requests; walks the cell store one read per cycle for queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rce_ctrl
  import rce_pkg::*;
#(
  parameter int MAX_SIDE = 64,
  parameter int SIDE_W   = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  req_valid,
  input  wire logic                  req_action,
  input  wire logic [5:0]            req_row,
  input  wire logic [5:0]            req_col,
  input  wire logic                  req_cell_value,
  output logic                       idle,
  input  wire logic [CNT_W-1:0]      n_rows,
  input  wire logic [CNT_W-1:0]      n_cols,
  output logic                       mem_we,
  output logic [2*SIDE_W-1:0]        mem_waddr,
  output logic                       mem_wdata,
  output logic                       mem_re,
  output logic [2*SIDE_W-1:0]        mem_raddr,
  input  wire logic                  mem_rdata,
  output logic                       res_valid,
  input  wire logic                  res_take,
  output rce_result_t                res
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SELF  = 7'b0000010,
    S_TOP   = 7'b0000100,
    S_LEFT  = 7'b0001000,
    S_DOWN  = 7'b0010000,
    S_RIGHT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] h_r, h_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic             corner_r, corner_nxt;

  logic [CNT_W-1:0] rd_row, rd_col;
  logic             go_down, go_right;
  logic             wr_in_store;

  assign wr_in_store = (32'(req_row) < MAX_SIDE) && (32'(req_col) < MAX_SIDE);

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    ptr_nxt    = ptr_r;
    h_nxt      = h_r;
    w_nxt      = w_r;
    corner_nxt = corner_r;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    rd_row     = row_r;
    rd_col     = col_r;
    go_down    = 1'b0;
    go_right   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          if (req_action == ACT_WRITE) begin
            mem_we = wr_in_store;
          end else begin
            row_nxt    = {1'b0, req_row};
            col_nxt    = {1'b0, req_col};
            h_nxt      = '0;
            w_nxt      = '0;
            corner_nxt = 1'b0;
            // outside the used area: no corner, no reads
            if (({1'b0, req_row} < n_rows) && ({1'b0, req_col} < n_cols)) begin
              mem_re    = 1'b1;
              rd_row    = {1'b0, req_row};
              rd_col    = {1'b0, req_col};
              state_nxt = S_SELF;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_SELF: begin
        if (!mem_rdata) begin
          state_nxt = S_DONE;
        end else if (row_r != '0) begin
          mem_re    = 1'b1;
          rd_row    = row_r - 1'b1;
          state_nxt = S_TOP;
        end else if (col_r != '0) begin
          mem_re    = 1'b1;
          rd_col    = col_r - 1'b1;
          state_nxt = S_LEFT;
        end else begin
          go_down = 1'b1;
        end
      end
      S_TOP: begin
        if (mem_rdata) begin
          state_nxt = S_DONE;
        end else if (col_r != '0) begin
          mem_re    = 1'b1;
          rd_col    = col_r - 1'b1;
          state_nxt = S_LEFT;
        end else begin
          go_down = 1'b1;
        end
      end
      S_LEFT: begin
        if (mem_rdata) begin
          state_nxt = S_DONE;
        end else begin
          go_down = 1'b1;
        end
      end
      S_DOWN: begin
        if (mem_rdata) begin
          h_nxt = h_r + 1'b1;
          if ((ptr_r + 1'b1) < n_rows) begin
            mem_re  = 1'b1;
            rd_row  = ptr_r + 1'b1;
            ptr_nxt = ptr_r + 1'b1;
          end else begin
            go_right = 1'b1;
          end
        end else begin
          go_right = 1'b1;
        end
      end
      S_RIGHT: begin
        if (mem_rdata) begin
          w_nxt = w_r + 1'b1;
          if ((ptr_r + 1'b1) < n_cols) begin
            mem_re  = 1'b1;
            rd_col  = ptr_r + 1'b1;
            ptr_nxt = ptr_r + 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // corner confirmed: the corner cell itself opens both runs
    if (go_down) begin
      corner_nxt = 1'b1;
      h_nxt      = 7'd1;
      if ((row_r + 1'b1) < n_rows) begin
        mem_re    = 1'b1;
        rd_row    = row_r + 1'b1;
        ptr_nxt   = row_r + 1'b1;
        state_nxt = S_DOWN;
      end else begin
        go_right = 1'b1;
      end
    end

    if (go_right) begin
      w_nxt = 7'd1;
      if ((col_r + 1'b1) < n_cols) begin
        mem_re    = 1'b1;
        rd_row    = row_r;
        rd_col    = col_r + 1'b1;
        ptr_nxt   = col_r + 1'b1;
        state_nxt = S_RIGHT;
      end else begin
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    ptr_r    <= ptr_nxt;
    h_r      <= h_nxt;
    w_r      <= w_nxt;
    corner_r <= corner_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign mem_waddr = {SIDE_W'(req_row), SIDE_W'(req_col)};
  assign mem_wdata = req_cell_value;
  assign mem_raddr = {SIDE_W'(rd_row), SIDE_W'(rd_col)};
  assign res_valid = (state_r == S_DONE);

  assign res.is_corner = corner_r;
  assign res.width     = w_r;
  assign res.height    = h_r;

endmodule

`default_nettype wire

// ===== tb/rce_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// rce_tb_pkg: corner scoreboard for the rectangle corner extent testbench
// Keeps a shadow copy of the cell map and the two extent registers, works out
// the corner result of every accepted query and checks the results returned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rce_tb_pkg;

  import rce_pkg::*;

  localparam int SIDE = 64;

  class corner_scoreboard;

    bit               cells [SIDE][SIDE];
    bit               written [SIDE][SIDE];
    logic [CNT_W-1:0] rows_used;
    logic [CNT_W-1:0] cols_used;
    rce_result_t      expected_corners [$];
    int               mismatches;

    function new();
      rows_used  = 7'd64;
      cols_used  = 7'd64;
      mismatches = 0;
    endfunction

    function void set_register(logic index, logic [CNT_W-1:0] value);
      if (index == REG_ROWS_USED)
        rows_used = value;
      else
        cols_used = value;
    endfunction

    function rce_result_t predict_corner(logic [5:0] row, logic [5:0] col);
      rce_result_t res;
      int          nr, nc, r, c, i;
      bit          top_clear, left_clear;
      res = '0;
      r   = row;
      c   = col;
      // registers above the map size act as the full map
      nr  = (rows_used > SIDE) ? SIDE : rows_used;
      nc  = (cols_used > SIDE) ? SIDE : cols_used;
      if (r < nr && c < nc && cells[r][c]) begin
        top_clear  = (r == 0) || !cells[r-1][c];
        left_clear = (c == 0) || !cells[r][c-1];
        if (top_clear && left_clear) begin
          res.is_corner = 1'b1;
          for (i = r; i < nr && cells[i][c]; i++)
            res.height = res.height + 1'b1;
          for (i = c; i < nc && cells[r][i]; i++)
            res.width = res.width + 1'b1;
        end
      end
      return res;
    endfunction

    // first cell that a query at (row, col) reads while it was never written
    function bit first_unwritten(logic [5:0] row, logic [5:0] col, output int ur,
                                 output int uc);
      int nr, nc, r, c, i;
      bit top_clear, left_clear;
      r  = row;
      c  = col;
      ur = r;
      uc = c;
      nr = (rows_used > SIDE) ? SIDE : rows_used;
      nc = (cols_used > SIDE) ? SIDE : cols_used;
      if (r >= nr || c >= nc)
        return 1'b0;
      if (!written[r][c])
        return 1'b1;
      if (!cells[r][c])
        return 1'b0;
      if (r > 0 && !written[r-1][c]) begin
        ur = r - 1;
        return 1'b1;
      end
      if (c > 0 && !written[r][c-1]) begin
        uc = c - 1;
        return 1'b1;
      end
      top_clear  = (r == 0) || !cells[r-1][c];
      left_clear = (c == 0) || !cells[r][c-1];
      if (!(top_clear && left_clear))
        return 1'b0;
      for (i = r; i < nr; i++) begin
        if (!written[i][c]) begin
          ur = i;
          return 1'b1;
        end
        if (!cells[i][c])
          break;
      end
      for (i = c; i < nc; i++) begin
        if (!written[r][i]) begin
          uc = i;
          return 1'b1;
        end
        if (!cells[r][i])
          break;
      end
      return 1'b0;
    endfunction

    function void note_request(logic action, logic [5:0] row, logic [5:0] col,
                               logic value);
      if (action == ACT_WRITE) begin
        cells[row][col]   = value;
        written[row][col] = 1'b1;
      end else begin
        expected_corners.push_back(predict_corner(row, col));
      end
    endfunction

    function void check_result(logic is_corner, logic [CNT_W-1:0] width,
                               logic [CNT_W-1:0] height);
      rce_result_t exp;
      if (expected_corners.size() == 0) begin
        $error("unexpected result: is_corner %0d width %0d height %0d",
               is_corner, width, height);
        mismatches++;
        return;
      end
      exp = expected_corners.pop_front();
      if (exp.is_corner !== is_corner) begin
        $error("is_corner: expected %0d, got %0d", exp.is_corner, is_corner);
        mismatches++;
      end
      if (exp.width !== width) begin
        $error("width: expected %0d, got %0d", exp.width, width);
        mismatches++;
      end
      if (exp.height !== height) begin
        $error("height: expected %0d, got %0d", exp.height, height);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_corners.size();
    endfunction

  endclass

endpackage

// ===== tb/tb_rectangle_corner_extent.sv =====
// ----------------------------------------------------------------------------
// tb_rectangle_corner_extent: testbench for the rectangle corner extent block
// Writes zeros ahead of each query into any cell it would read unwritten, runs
// a few directed corner queries, then several extent settings (extremes
// included) with random L-shaped regions, stray writes and stray queries.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rectangle_corner_extent;

  import rce_pkg::*;
  import rce_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 140;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 200;

  logic             clk;
  logic             rst_n         = 1'b0;
  logic             cfg_we        = 1'b0;
  logic             cfg_index     = REG_ROWS_USED;
  logic [CNT_W-1:0] cfg_wdata     = '0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic             in_action     = ACT_WRITE;
  logic [5:0]       in_row        = '0;
  logic [5:0]       in_col        = '0;
  logic             in_cell_value = 1'b0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic             out_is_corner;
  logic [CNT_W-1:0] out_width;
  logic [CNT_W-1:0] out_height;

  corner_scoreboard sb;
  bit               gaps_on       = 1'b0;
  int               requests_sent = 0;
  int               stall_left    = 0;
  int               quiet_cycles  = 0;
  logic [CNT_W-1:0] phase_rows [PHASES];
  logic [CNT_W-1:0] phase_cols [PHASES];

  rectangle_corner_extent #(.MAX_SIDE(SIDE)) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_corner (out_is_corner),
    .out_width     (out_width),
    .out_height    (out_height)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (!gaps_on)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    else if (roll < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  task automatic drive_request(logic action, logic [5:0] row, logic [5:0] col,
                               logic value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= action;
    in_row        <= row;
    in_col        <= col;
    in_cell_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(action, row, col, value);
    requests_sent++;
  endtask

  // a query never reads a cell that was not written: zeros go in first
  task automatic send_request(logic action, logic [5:0] row, logic [5:0] col,
                              logic value);
    int ur, uc;
    if (action == ACT_QUERY) begin
      while (sb.first_unwritten(row, col, ur, uc))
        drive_request(ACT_WRITE, 6'(ur), 6'(uc), 1'b0);
    end
    drive_request(action, row, col, value);
  endtask

  task automatic set_extent(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_USED;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= REG_COLS_USED;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_register(REG_ROWS_USED, rows);
    sb.set_register(REG_COLS_USED, cols);
  endtask

  // drop valid, wait for every outstanding query, then let writes settle
  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // writes the top row and left column of a rectangle, fences it with zeros
  // most of the time, then asks for its corner and sometimes for a cell within it
  task automatic draw_and_query();
    int r0, c0, h, w, i, lim;
    if ($urandom_range(0, 9) == 0) begin
      r0 = $urandom_range(0, 3);
      c0 = $urandom_range(0, 3);
      h  = $urandom_range(1, SIDE - r0);
      w  = $urandom_range(1, SIDE - c0);
    end else begin
      r0  = $urandom_range(0, SIDE - 1);
      c0  = $urandom_range(0, SIDE - 1);
      lim = (SIDE - r0 < 6) ? SIDE - r0 : 6;
      h   = $urandom_range(1, lim);
      lim = (SIDE - c0 < 6) ? SIDE - c0 : 6;
      w   = $urandom_range(1, lim);
    end
    if (r0 > 0 && $urandom_range(0, 4) != 0)
      send_request(ACT_WRITE, 6'(r0 - 1), 6'(c0), 1'b0);
    if (c0 > 0 && $urandom_range(0, 4) != 0)
      send_request(ACT_WRITE, 6'(r0), 6'(c0 - 1), 1'b0);
    for (i = 0; i < w; i++)
      send_request(ACT_WRITE, 6'(r0), 6'(c0 + i), 1'b1);
    for (i = 1; i < h; i++)
      send_request(ACT_WRITE, 6'(r0 + i), 6'(c0), 1'b1);
    if (r0 + h < SIDE && $urandom_range(0, 3) != 0)
      send_request(ACT_WRITE, 6'(r0 + h), 6'(c0), 1'b0);
    if (c0 + w < SIDE && $urandom_range(0, 3) != 0)
      send_request(ACT_WRITE, 6'(r0), 6'(c0 + w), 1'b0);
    send_request(ACT_QUERY, 6'(r0), 6'(c0), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0)
      send_request(ACT_QUERY, 6'(r0 + $urandom_range(0, h - 1)),
                   6'(c0 + $urandom_range(0, w - 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_requests(int count);
    int target, kind;
    target = requests_sent + count;
    while (requests_sent < target) begin
      if ($urandom_range(0, 39) == 0)
        gaps_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind <= 5)
        draw_and_query();
      else if (kind <= 7)
        send_request(ACT_WRITE, 6'($urandom_range(0, SIDE - 1)),
                     6'($urandom_range(0, SIDE - 1)), 1'($urandom_range(0, 1)));
      else
        send_request(ACT_QUERY, 6'($urandom_range(0, SIDE - 1)),
                     6'($urandom_range(0, SIDE - 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // result side: random stall, check each accepted result
  always @(posedge clk) begin : result_side
    int gap;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(out_is_corner, out_width, out_height);
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        gap        = pick_gap();
        out_stall  <= (gap > 0);
        stall_left <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rectangle_corner_extent failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int p;
    sb = new();
    phase_rows = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd64, 7'd1, 7'd65, 7'd0, 7'd0, 7'd0};
    phase_cols = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd1, 7'd64, 7'd3, 7'd0, 7'd0, 7'd0};
    for (p = 7; p < PHASES; p++) begin
      phase_rows[p] = CNT_W'($urandom_range(1, SIDE));
      phase_cols[p] = CNT_W'($urandom_range(1, SIDE));
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset extents, single cells, map edges, neighbour blocking
    gaps_on = 1'b1;
    send_request(ACT_QUERY, 0, 0, 1'b1);
    send_request(ACT_WRITE, 0, 0, 1'b1);
    send_request(ACT_QUERY, 0, 0, 1'b0);
    send_request(ACT_WRITE, 63, 63, 1'b1);
    send_request(ACT_QUERY, 63, 63, 1'b1);
    send_request(ACT_WRITE, 0, 1, 1'b1);
    send_request(ACT_QUERY, 0, 1, 1'b0);
    send_request(ACT_QUERY, 0, 0, 1'b0);
    send_request(ACT_WRITE, 1, 0, 1'b1);
    send_request(ACT_QUERY, 0, 0, 1'b0);
    send_request(ACT_QUERY, 1, 0, 1'b0);
    send_request(ACT_WRITE, 1, 0, 1'b0);
    send_request(ACT_QUERY, 0, 0, 1'b1);
    send_request(ACT_QUERY, 63, 0, 1'b0);
    send_request(ACT_WRITE, 62, 63, 1'b1);
    send_request(ACT_QUERY, 63, 63, 1'b0);
    send_request(ACT_QUERY, 62, 63, 1'b0);
    drain(8);

    for (p = 0; p < PHASES; p++) begin
      set_extent(phase_rows[p], phase_cols[p]);
      random_requests(PHASE_ITEMS);
      drain(8);
    end

    drain(SETTLE_CYCLES);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("tb_rectangle_corner_extent passed");
    else
      $display("tb_rectangle_corner_extent failed");
    $finish;
  end

endmodule
